### rtl/mdec_pkg.sv
`timescale 1ns / 1ps

package mdec_pkg;

	localparam int DATA_W      = 16;
	localparam int CD_W        = 16;
	localparam int OP_W        = 2;
	localparam int CH_W        = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int CHANNELS_DEF = 16;
	localparam int COUNT_W_DEF  = 16;

	localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
	localparam logic [OP_W-1:0] OP_PRESET = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNTER  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd2;

	typedef struct packed {
		logic sample;
		logic preset;
		logic clear;
	} lane_ctrl_t;

	typedef struct packed {
		logic stable_d;
		logic fire;
	} lane_stat_t;

endpackage

### rtl/mdec_lane.sv
`timescale 1ns / 1ps

module mdec_lane #(
	parameter int COUNT_WIDTH = mdec_pkg::COUNT_W_DEF
) (
	input  mdec_pkg::lane_ctrl_t          ctrl,
	input  logic                          active,
	input  logic                          counter_mode,
	input  logic                          raw,
	input  logic                          preset,
	input  logic                          clear_sel,
	input  logic                          stable,
	input  logic [mdec_pkg::CD_W-1:0]     reload,
	input  logic [mdec_pkg::CD_W-1:0]     countdown,
	input  logic [COUNT_WIDTH-1:0]        count,
	output logic [mdec_pkg::CD_W-1:0]     countdown_d,
	output logic [COUNT_WIDTH-1:0]        count_d,
	output mdec_pkg::lane_stat_t          stat
);
	import mdec_pkg::*;

	logic            filt;
	logic            mismatch;
	logic [CD_W-1:0] cd_upd;
	logic            fire;

	assign filt     = ctrl.sample && active;
	assign mismatch = raw != stable;
	assign cd_upd   = (countdown != '0) ? countdown - CD_W'(1) : reload;
	assign fire     = filt && mismatch && (cd_upd == '0);

	always_comb begin
		countdown_d = countdown;
		if (filt) begin
			countdown_d = mismatch ? cd_upd : '0;
		end
	end

	always_comb begin
		count_d = count;
		if (fire) begin
			if (counter_mode && raw) begin
				count_d = count + COUNT_WIDTH'(1);
			end else begin
				count_d = {{(COUNT_WIDTH-1){1'b0}}, raw};
			end
		end else if (ctrl.clear && clear_sel && active && counter_mode) begin
			count_d = '0;
		end
	end

	always_comb begin
		stat.fire     = fire;
		stat.stable_d = stable;
		if (ctrl.preset) begin
			stat.stable_d = preset;
		end else if (fire) begin
			stat.stable_d = raw;
		end
	end

endmodule

### rtl/multichannel_debounce_edge_counter.sv
`timescale 1ns / 1ps

// Multichannel debounce filter with per-channel rising-edge counters.
// Input beats carry an opcode (sample, preset stable bits, clear one counter),
// raw sample bits, preset bits and a channel index. Every input beat yields
// exactly one result beat with a change flag, the stable bits and the level or
// edge count of the indexed channel.
// A beat is captured in an input register, then all channels are updated in
// parallel when the beat advances, which also loads the result register. One
// beat is accepted per cycle as long as the output side takes results; the
// per-channel update between the input and result registers sets that rate.
// When the receiver stalls, the result is held and the input register keeps
// one more beat before in_stall rises.
// Reset clears the configuration registers, the stable bits, all countdowns
// and all counts; no results are pending after reset.
// Configuration is written through cfg_we, cfg_index and cfg_wdata; the user
// must write it only while the block is idle, which the block does not enforce.

module multichannel_debounce_edge_counter #(
	parameter int CHANNELS    = mdec_pkg::CHANNELS_DEF,
	parameter int COUNT_WIDTH = mdec_pkg::COUNT_W_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [mdec_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mdec_pkg::DATA_W-1:0]        cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [mdec_pkg::OP_W-1:0]          opcode,
	input  logic [mdec_pkg::DATA_W-1:0]        sample_bits,
	input  logic [mdec_pkg::DATA_W-1:0]        preset_bits,
	input  logic [mdec_pkg::CH_W-1:0]          channel,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               changed,
	output logic [mdec_pkg::DATA_W-1:0]        stable_bits,
	output logic [mdec_pkg::DATA_W-1:0]        channel_value
);
	import mdec_pkg::*;

	logic [DATA_W-1:0] active_q;
	logic [DATA_W-1:0] counter_q;
	logic [CD_W-1:0]   reload_q;

	logic              valid_s1;
	logic [OP_W-1:0]   op_s1;
	logic [DATA_W-1:0] sample_s1;
	logic [DATA_W-1:0] preset_s1;
	logic [CH_W-1:0]   channel_s1;

	logic [CHANNELS-1:0]    stable_q;
	logic [CD_W-1:0]        countdown_q [CHANNELS];
	logic [COUNT_WIDTH-1:0] count_q     [CHANNELS];

	logic [CHANNELS-1:0]    stable_d;
	logic [CHANNELS-1:0]    fire;
	logic [CD_W-1:0]        countdown_d [CHANNELS];
	logic [COUNT_WIDTH-1:0] count_d     [CHANNELS];

	lane_ctrl_t             ctrl;
	logic                   adv;
	logic [COUNT_WIDTH-1:0] sel_count;
	logic [DATA_W-1:0]      value_d;
	logic [DATA_W-1:0]      stable_out_d;

	assign adv      = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !adv;

	assign ctrl.sample = op_s1 == OP_SAMPLE;
	assign ctrl.preset = op_s1 == OP_PRESET;
	assign ctrl.clear  = op_s1 == OP_CLEAR;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= '0;
			counter_q <= '0;
			reload_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ACTIVE:   active_q  <= cfg_wdata;
				CFG_COUNTER:  counter_q <= cfg_wdata;
				CFG_DEBOUNCE: reload_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1      <= opcode;
			sample_s1  <= sample_bits;
			preset_s1  <= preset_bits;
			channel_s1 <= channel;
		end
	end

	for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
		logic       raw;
		logic       pre;
		logic       act;
		logic       cnt_mode;
		lane_stat_t stat;

		if (i < DATA_W) begin : g_in
			assign raw      = sample_s1[i];
			assign pre      = preset_s1[i];
			assign act      = active_q[i];
			assign cnt_mode = counter_q[i];
		end else begin : g_out
			assign raw      = 1'b0;
			assign pre      = 1'b0;
			assign act      = 1'b0;
			assign cnt_mode = 1'b0;
		end

		mdec_lane #(
			.COUNT_WIDTH(COUNT_WIDTH)
		) u_lane (
			.ctrl        (ctrl),
			.active      (act),
			.counter_mode(cnt_mode),
			.raw         (raw),
			.preset      (pre),
			.clear_sel   (int'(channel_s1) == i),
			.stable      (stable_q[i]),
			.reload      (reload_q),
			.countdown   (countdown_q[i]),
			.count       (count_q[i]),
			.countdown_d (countdown_d[i]),
			.count_d     (count_d[i]),
			.stat        (stat)
		);

		assign stable_d[i] = stat.stable_d;
		assign fire[i]     = stat.fire;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stable_q[i]    <= 1'b0;
				countdown_q[i] <= '0;
				count_q[i]     <= '0;
			end else if (adv) begin
				stable_q[i]    <= stable_d[i];
				countdown_q[i] <= countdown_d[i];
				count_q[i]     <= count_d[i];
			end
		end
	end

	always_comb begin
		sel_count = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (int'(channel_s1) == i) begin
				sel_count = count_d[i];
			end
		end
	end

	if (COUNT_WIDTH >= DATA_W) begin : g_val_trunc
		assign value_d = sel_count[DATA_W-1:0];
	end else begin : g_val_ext
		assign value_d = {{(DATA_W-COUNT_WIDTH){1'b0}}, sel_count};
	end

	if (CHANNELS >= DATA_W) begin : g_stb_trunc
		assign stable_out_d = stable_d[DATA_W-1:0];
	end else begin : g_stb_ext
		assign stable_out_d = {{(DATA_W-CHANNELS){1'b0}}, stable_d};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			changed       <= |fire;
			stable_bits   <= stable_out_d;
			channel_value <= value_d;
		end
	end

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && out_stall))
		else $error("input stalled without a held result");

	a_change_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && op_s1 != OP_SAMPLE) |=> !changed)
		else $error("change flagged on a non-sample beat");

	a_fire_active: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (|fire)) |-> ctrl.sample)
		else $error("channel accepted a new bit outside a sample beat");

endmodule

### verif/tb_multichannel_debounce_edge_counter.sv
`timescale 1ns / 1ps

module tb_multichannel_debounce_edge_counter;
	import mdec_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SHOWN_MISMATCHES = 10;
	localparam int SETTLE_CYCLES = 4;
	localparam int LONG_HOLD = 300;

	typedef struct packed {
		logic              changed;
		logic [DATA_W-1:0] stable;
		logic [DATA_W-1:0] value;
	} filter_report_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0]    cfg_wdata;
	logic                 in_valid;
	logic                 in_stall;
	logic [OP_W-1:0]      opcode;
	logic [DATA_W-1:0]    sample_bits;
	logic [DATA_W-1:0]    preset_bits;
	logic [CH_W-1:0]      channel;
	logic                 out_valid;
	logic                 out_stall;
	logic                 changed;
	logic [DATA_W-1:0]    stable_bits;
	logic [DATA_W-1:0]    channel_value;

	multichannel_debounce_edge_counter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.sample_bits  (sample_bits),
		.preset_bits  (preset_bits),
		.channel      (channel),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.changed      (changed),
		.stable_bits  (stable_bits),
		.channel_value(channel_value)
	);

	// Shadow copy of the filter state and its configuration.
	logic [DATA_W-1:0] active_copy;
	logic [DATA_W-1:0] counter_copy;
	logic [DATA_W-1:0] debounce_copy;
	logic [DATA_W-1:0] stable_copy;
	logic [CD_W-1:0]   countdown_copy [16];
	logic [DATA_W-1:0] level_count_copy [16];

	filter_report_t expected_reports[$];
	int mismatches;
	int beats_sent;
	int reports_seen;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_request;
	int hold_left;
	int quiet_cycles;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic void debounce_predict(input logic [OP_W-1:0] op,
			input logic [DATA_W-1:0] raw, input logic [DATA_W-1:0] preset,
			input logic [CH_W-1:0] ch);
		filter_report_t r;
		logic nb;
		r.changed = 1'b0;
		case (op)
			OP_SAMPLE: begin
				for (int i = 0; i < 16; i++) begin
					if (active_copy[i]) begin
						nb = raw[i];
						if (nb == stable_copy[i]) begin
							countdown_copy[i] = '0;
						end else begin
							if (countdown_copy[i] != 0)
								countdown_copy[i] = countdown_copy[i] - 1'b1;
							else
								countdown_copy[i] = debounce_copy;
							if (countdown_copy[i] == 0) begin
								if (counter_copy[i] && nb)
									level_count_copy[i] = level_count_copy[i] + 1'b1;
								else
									level_count_copy[i] = {15'b0, nb};
								stable_copy[i] = nb;
								r.changed = 1'b1;
							end
						end
					end
				end
			end
			OP_PRESET: begin
				stable_copy = preset;
			end
			OP_CLEAR: begin
				if (active_copy[ch] && counter_copy[ch])
					level_count_copy[ch] = '0;
			end
			default: begin
			end
		endcase
		r.stable = stable_copy;
		r.value = level_count_copy[ch];
		expected_reports.push_back(r);
	endfunction

	function automatic void flag_mismatch(input string why, input filter_report_t want,
			input filter_report_t got);
		mismatches++;
		if (mismatches <= SHOWN_MISMATCHES)
			$display("%s: expected changed=%0b stable=%h value=%h, got changed=%0b stable=%h value=%h",
				why, want.changed, want.stable, want.value, got.changed, got.stable, got.value);
	endfunction

	always @(posedge clk) begin : check_reports
		filter_report_t want;
		filter_report_t got;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = '{changed, stable_bits, channel_value};
				reports_seen++;
				if (expected_reports.size() == 0) begin
					flag_mismatch("result with none expected", '0, got);
				end else begin
					want = expected_reports.pop_front();
					if (want !== got)
						flag_mismatch("result mismatch", want, got);
				end
			end
			if (in_valid && !in_stall)
				debounce_predict(opcode, sample_bits, preset_bits, channel);
		end
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_request > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_request;
			hold_request = 0;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_beat(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] raw,
			input logic [DATA_W-1:0] preset, input logic [CH_W-1:0] ch);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		sample_bits <= raw;
		preset_bits <= preset;
		channel <= ch;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		beats_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (reports_seen != beats_sent)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [DATA_W-1:0] active, input logic [DATA_W-1:0] counting,
			input logic [DATA_W-1:0] debounce);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= CFG_ACTIVE;
		cfg_wdata <= active;
		@(posedge clk);
		cfg_index <= CFG_COUNTER;
		cfg_wdata <= counting;
		@(posedge clk);
		cfg_index <= CFG_DEBOUNCE;
		cfg_wdata <= debounce;
		@(posedge clk);
		cfg_we <= 1'b0;
		active_copy = active;
		counter_copy = counting;
		debounce_copy = debounce;
	endtask

	task automatic test_inactive_after_reset();
		send_beat(OP_SAMPLE, 16'hFFFF, 16'h0000, 4'd0);
		send_beat(OP_CLEAR, 16'h0000, 16'hFFFF, 4'd15);
	endtask

	task automatic test_zero_debounce();
		set_config(16'hFFFF, 16'hFF00, 16'h0000);
		send_beat(OP_SAMPLE, 16'hFFFF, 16'h0000, 4'd0);
		send_beat(OP_SAMPLE, 16'hFFFF, 16'h0000, 4'd15);
		send_beat(OP_SAMPLE, 16'h0000, 16'hFFFF, 4'd15);
		send_beat(OP_SAMPLE, 16'h5555, 16'h0000, 4'd8);
		send_beat(OP_PRESET, 16'h0000, 16'hFFFF, 4'd0);
		send_beat(OP_PRESET, 16'hFFFF, 16'h0000, 4'd1);
		send_beat(OP_SAMPLE, 16'hFF00, 16'h0000, 4'd9);
		send_beat(OP_CLEAR, 16'h0000, 16'h0000, 4'd9);
		send_beat(OP_CLEAR, 16'hFFFF, 16'hFFFF, 4'd0);
		send_beat(OP_UNUSED, 16'hFFFF, 16'hFFFF, 4'd7);
	endtask

	task automatic test_filter_delay();
		set_config(16'h7FFE, 16'hC003, 16'h0003);
		repeat (4) send_beat(OP_SAMPLE, 16'hFFFF, 16'h0000, 4'd1);
		send_beat(OP_SAMPLE, 16'h0000, 16'h0000, 4'd14);
		send_beat(OP_SAMPLE, 16'hFFFF, 16'h0000, 4'd14);
		send_beat(OP_CLEAR, 16'h0000, 16'h0000, 4'd15);
		send_beat(OP_CLEAR, 16'h0000, 16'h0000, 4'd1);
		set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_beat(OP_SAMPLE, 16'h0000, 16'h0000, 4'd2);
		send_beat(OP_SAMPLE, 16'h0000, 16'h0000, 4'd2);
		send_beat(OP_SAMPLE, 16'hFFFF, 16'h0000, 4'd3);
	endtask

	// A preset to zero re-arms the rising edge without the falling edge that
	// would clear the count, so the counts keep climbing.
	task automatic test_count_climb();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		set_config(16'hFFFF, 16'hFFFF, 16'h0000);
		for (int k = 0; k < 64; k++) begin
			send_beat(OP_PRESET, 16'h0000, 16'h0000, k[3:0]);
			send_beat(OP_SAMPLE, 16'hFFFF, 16'h0000, k[3:0]);
		end
		drain();
	endtask

	task automatic test_long_hold();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		set_config(16'hFFFF, 16'h0F0F, 16'h0001);
		hold_request = LONG_HOLD;
		for (int k = 0; k < 40; k++)
			send_beat(OP_SAMPLE, (k % 4 < 2) ? 16'hFFFF : 16'h0000, 16'h0000, k[3:0]);
		drain();
	endtask

	task automatic test_random(input int beats, input int idle_pct, input int stall_pct,
			input logic [DATA_W-1:0] active, input logic [DATA_W-1:0] counting,
			input logic [DATA_W-1:0] debounce);
		logic [DATA_W-1:0] level;
		logic [DATA_W-1:0] raw;
		logic [DATA_W-1:0] preset;
		logic [OP_W-1:0] op;
		int pick;
		set_config(active, counting, debounce);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		level = DATA_W'($urandom);
		for (int k = 0; k < beats; k++) begin
			pick = $urandom_range(99);
			preset = DATA_W'($urandom);
			raw = DATA_W'($urandom);
			if (pick < 72) begin
				op = OP_SAMPLE;
				if ($urandom_range(3) == 0)
					level = level ^ DATA_W'($urandom & $urandom & $urandom);
				if ($urandom_range(19) != 0)
					raw = level ^ (($urandom_range(4) == 0) ? (16'h1 << $urandom_range(15)) : 16'h0);
			end else if (pick < 84) begin
				op = OP_CLEAR;
			end else if (pick < 95) begin
				op = OP_PRESET;
				if ($urandom_range(1) == 0)
					preset = level;
			end else begin
				op = OP_UNUSED;
			end
			send_beat(op, raw, preset, CH_W'($urandom_range(15)));
			if (k % 150 == 149)
				drain();
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_ACTIVE;
		cfg_wdata = '0;
		in_valid = 1'b0;
		opcode = OP_SAMPLE;
		sample_bits = '0;
		preset_bits = '0;
		channel = '0;
		out_stall = 1'b0;
		mismatches = 0;
		beats_sent = 0;
		reports_seen = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 0;
		hold_left = 0;
		quiet_cycles = 0;
		active_copy = '0;
		counter_copy = '0;
		debounce_copy = '0;
		stable_copy = '0;
		for (int i = 0; i < 16; i++) begin
			countdown_copy[i] = '0;
			level_count_copy[i] = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_inactive_after_reset();
		test_zero_debounce();
		test_filter_delay();
		test_count_climb();
		test_long_hold();
		test_random(350, 0, 0, 16'hFFFF, DATA_W'($urandom), 16'h0000);
		test_random(350, 65, 0, DATA_W'($urandom), DATA_W'($urandom),
			DATA_W'($urandom_range(1, 3)));
		test_random(350, 0, 65, DATA_W'($urandom), 16'hFFFF, DATA_W'($urandom_range(0, 2)));
		test_random(350, 15, 15, 16'hFFFF, 16'h0000, 16'h0002);

		drain();
		if (mismatches == 0 && expected_reports.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
